// ----- src/lirs_pkg.sv -----
// Shared types and constants for the linear interpolation resampler.
`timescale 1ns / 1ps
package lirs_pkg;

    localparam int CHANNELS  = 2;
    localparam int SAMPLE_W  = 16;
    localparam int FRAC_BITS = 16;
    localparam int PHASE_W   = 23;
    localparam int DIFF_W    = SAMPLE_W + 1;
    localparam int PROD_W    = DIFF_W + FRAC_BITS + 1;

    localparam logic [PHASE_W-1:0] ONE_FX    = PHASE_W'(1 << FRAC_BITS);
    localparam logic [PHASE_W-1:0] RATIO_MIN = PHASE_W'(1 << (FRAC_BITS - 6));
    localparam logic [PHASE_W-1:0] RATIO_MAX = PHASE_W'(1 << (FRAC_BITS + 6));

    // register index decode (one register, index taken from paddr[2])
    localparam logic REG_STEP_RATIO = 1'b0;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef sample_t [CHANNELS-1:0] frame_t;

    typedef struct packed {
        frame_t prev;
        frame_t cur;
        logic   primed;
    } entry_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

endpackage

// ----- src/linear_interp_resampler_unit.sv -----
// Top level of the linear interpolation sample-rate converter.
`timescale 1ns / 1ps
// Stereo linear-interpolation resampler. Each input item is a frame of two
// 16-bit signed samples; each result item is an interpolated frame plus
// run_end, set on the last result an input frame produces. The first frame
// after reset only primes the history and yields nothing. The phase
// advances by step_ratio (unsigned, 16 fraction bits, clamped to 1/64..64)
// per result, so one input yields 0 to 64 results. The back end pops an
// input, then for each result multiplies in the evaluate state and
// loads the output register in the emit state, which waits while the
// output side stalls; a final evaluate step closes the input. A FIFO
// of QUEUE_DEPTH frame pairs lets the input side keep accepting while
// the back end works or the output side stalls. step_ratio sits at APB
// byte address 0 and must only be written while the block is idle.
module linear_interp_resampler_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // config port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    // input items
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic signed [15:0]    s_left_in,
    input  logic signed [15:0]    s_right_in,
    // result items
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic signed [15:0]    m_left_out,
    output logic signed [15:0]    m_right_out,
    output logic                  m_run_end
);

    logic [lirs_pkg::PHASE_W-1:0] ratio_reg;
    logic [lirs_pkg::PHASE_W-1:0] ratio_clamped;
    logic                         cfg_wr;

    lirs_pkg::frame_t    cur_frame;
    lirs_pkg::frame_t    out_frame;
    lirs_pkg::entry_t    push_entry;
    lirs_pkg::entry_t    head_entry;
    lirs_pkg::q_status_t q_stat;
    logic                push;
    logic                pop;

    // APB: zero-wait, write lands on the access phase
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                 && (paddr[2] == lirs_pkg::REG_STEP_RATIO);
    assign prdata = (paddr[2] == lirs_pkg::REG_STEP_RATIO) ?
                    {{(32 - lirs_pkg::PHASE_W){1'b0}}, ratio_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn)
            ratio_reg <= lirs_pkg::ONE_FX;
        else if (cfg_wr)
            ratio_reg <= pwdata[lirs_pkg::PHASE_W-1:0];
    end

    // saturate the step into 1/64..64 so a run never exceeds 64 results
    always_comb begin
        if (ratio_reg < lirs_pkg::RATIO_MIN)
            ratio_clamped = lirs_pkg::RATIO_MIN;
        else if (ratio_reg > lirs_pkg::RATIO_MAX)
            ratio_clamped = lirs_pkg::RATIO_MAX;
        else
            ratio_clamped = ratio_reg;
    end

    // channel 0 = left, channel 1 = right
    always_comb begin
        cur_frame[0] = s_left_in;
        cur_frame[1] = s_right_in;
    end

    assign m_left_out  = out_frame[0];
    assign m_right_out = out_frame[1];

    lirs_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .cur_frame  (cur_frame),
        .q_stat     (q_stat),
        .push       (push),
        .push_entry (push_entry)
    );

    lirs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .q_stat     (q_stat)
    );

    lirs_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ratio      (ratio_clamped),
        .head_entry (head_entry),
        .q_stat     (q_stat),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .out_frame  (out_frame),
        .out_end    (m_run_end)
    );

endmodule

// ----- src/lirs_front.sv -----
// Front end: accepts input frames and pairs each with the frame before it.
`timescale 1ns / 1ps
module lirs_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  lirs_pkg::frame_t    cur_frame,
    input  lirs_pkg::q_status_t q_stat,
    output logic                push,
    output lirs_pkg::entry_t    push_entry
);

    logic             primed_reg;
    lirs_pkg::frame_t prev_reg;

    assign s_ready = !q_stat.full;
    assign push    = s_valid && s_ready;

    always_comb begin
        push_entry.prev   = prev_reg;
        push_entry.cur    = cur_frame;
        push_entry.primed = primed_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            primed_reg <= 1'b0;
            prev_reg   <= '0;
        end else if (push) begin
            primed_reg <= 1'b1;
            prev_reg   <= cur_frame;
        end
    end

endmodule

// ----- src/lirs_queue.sv -----
// Short FIFO of frame pairs between front and back.
`timescale 1ns / 1ps
module lirs_queue #(
    parameter int DEPTH = 2
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  lirs_pkg::entry_t    push_entry,
    input  logic                pop,
    output lirs_pkg::entry_t    head_entry,
    output lirs_pkg::q_status_t q_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    lirs_pkg::entry_t   slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;

    assign q_stat.empty = (cnt_reg == '0);
    assign q_stat.full  = (cnt_reg == CNT_W'(DEPTH));
    assign head_entry   = slot_reg[rd_ptr_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + CNT_W'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
    end

endmodule

// ----- src/lirs_back.sv -----
// Back end: phase stepping, per-channel interpolation and output register.
`timescale 1ns / 1ps
module lirs_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [lirs_pkg::PHASE_W-1:0]   ratio,
    input  lirs_pkg::entry_t               head_entry,
    input  lirs_pkg::q_status_t            q_stat,
    output logic                           pop,
    output logic                           m_valid,
    input  logic                           m_ready,
    output lirs_pkg::frame_t               out_frame,
    output logic                           out_end
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EVAL = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    localparam int CH = lirs_pkg::CHANNELS;
    localparam int FB = lirs_pkg::FRAC_BITS;
    localparam int SW = lirs_pkg::SAMPLE_W;

    logic [1:0]                       state_reg, state_next;
    logic [lirs_pkg::PHASE_W-1:0]     phase_reg, phase_next;
    logic                             primed_reg, primed_next;
    logic                             last_reg, last_next;
    lirs_pkg::frame_t                 prev_reg, prev_next;
    logic signed [lirs_pkg::DIFF_W-1:0] diff_reg [CH];
    logic signed [lirs_pkg::DIFF_W-1:0] diff_next [CH];
    logic signed [lirs_pkg::PROD_W-1:0] prod_reg [CH];
    logic signed [lirs_pkg::PROD_W-1:0] prod_next [CH];
    logic                             out_valid_reg, out_valid_next;
    lirs_pkg::frame_t                 out_frame_reg, out_frame_next;
    logic                             out_end_reg, out_end_next;

    logic signed [FB:0]               phase_frac;
    logic [lirs_pkg::PHASE_W-1:0]     phase_step;
    logic                             emit_ok;
    logic                             load_out;

    assign phase_frac = $signed({1'b0, phase_reg[FB-1:0]});
    assign phase_step = phase_reg + ratio;
    assign emit_ok    = !out_valid_reg || m_ready;

    assign m_valid   = out_valid_reg;
    assign out_frame = out_frame_reg;
    assign out_end   = out_end_reg;

    always_comb begin
        logic signed [lirs_pkg::PROD_W-1:0] quot;
        logic                               corr;
        logic [SW-1:0]                      q16;

        state_next     = state_reg;
        phase_next     = phase_reg;
        primed_next    = primed_reg;
        last_next      = last_reg;
        prev_next      = prev_reg;
        diff_next      = diff_reg;
        prod_next      = prod_reg;
        out_frame_next = out_frame_reg;
        out_end_next   = out_end_reg;
        pop            = 1'b0;
        load_out       = 1'b0;
        quot           = '0;
        corr           = 1'b0;
        q16            = '0;

        case (state_reg)
            ST_IDLE: begin
                if (!q_stat.empty) begin
                    pop         = 1'b1;
                    primed_next = head_entry.primed;
                    prev_next   = head_entry.prev;
                    for (int c = 0; c < CH; c++) begin
                        diff_next[c] = $signed({head_entry.cur[c][SW-1], head_entry.cur[c]})
                                     - $signed({head_entry.prev[c][SW-1], head_entry.prev[c]});
                    end
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (primed_reg && (phase_reg < lirs_pkg::ONE_FX)) begin
                    for (int c = 0; c < CH; c++)
                        prod_next[c] = diff_reg[c] * phase_frac;
                    phase_next = phase_step;
                    last_next  = (phase_step >= lirs_pkg::ONE_FX);
                    state_next = ST_EMIT;
                end else begin
                    // end of run: drop one whole input period (a phase below one restarts at zero)
                    phase_next = (phase_reg >= lirs_pkg::ONE_FX) ?
                                 phase_reg - lirs_pkg::ONE_FX : '0;
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (emit_ok) begin
                    load_out = 1'b1;
                    for (int c = 0; c < CH; c++) begin
                        // scale down, rounding toward zero
                        quot = prod_reg[c] >>> FB;
                        corr = prod_reg[c][lirs_pkg::PROD_W-1] && (|prod_reg[c][FB-1:0]);
                        q16  = quot[SW-1:0] + SW'(corr);
                        out_frame_next[c] = $signed(prev_reg[c] + q16);
                    end
                    out_end_next = last_reg;
                    state_next   = ST_EVAL;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (load_out)
            out_valid_next = 1'b1;
        else if (m_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            phase_reg     <= lirs_pkg::ONE_FX;
            primed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            primed_reg    <= primed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        last_reg      <= last_next;
        prev_reg      <= prev_next;
        diff_reg      <= diff_next;
        prod_reg      <= prod_next;
        out_frame_reg <= out_frame_next;
        out_end_reg   <= out_end_next;
    end

    a_phase_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg < (lirs_pkg::ONE_FX + lirs_pkg::RATIO_MAX))
        else $error("phase accumulator out of range");

    a_mid_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && emit_ok && !last_reg)
        |=> (state_reg == ST_EVAL && phase_reg < lirs_pkg::ONE_FX))
        else $error("non-final output left phase at or above one");

    a_end_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && emit_ok && last_reg)
        |=> (phase_reg >= lirs_pkg::ONE_FX))
        else $error("final output left phase below one");

    a_out_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(state_reg == ST_EMIT))
        else $error("output raised outside emit state");

endmodule
